// ===== rtl/ffs_pkg.sv =====
// Shared types, constants and helper functions for the fold/spin iteration pipeline.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package ffs_pkg;

  localparam int ANG_BITS = 30;
  localparam int FAC_BITS = 24;
  localparam int ROT_BITS = 18;
  localparam int NUM_W    = 32 + FAC_BITS;

  localparam logic [29:0] K_Q30    = 30'd652032874;
  localparam logic [26:0] C01_Q30  = 27'd107374182;
  localparam logic [26:0] C005_Q30 = 27'd53687091;

  localparam logic [47:0] DMAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ONE_Q24  = 48'h00_0001_000000;
  localparam logic [NUM_W-1:0] FACTOR_CAP = {32'hFFFF_FFFF, {FAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    CFG_SPIN_GAIN,
    CFG_MIN_RADIUS_SQ,
    CFG_MAX_RADIUS_SQ,
    CFG_UNIFORM_SCALE,
    CFG_ROTATE_ON,
    CFG_ROT_ROW_A,
    CFG_ROT_ROW_B,
    CFG_ROT_ROW_C
  } cfg_idx_t;

  // Settings as the datapath consumes them, derived from the register file.
  typedef struct packed {
    logic signed [28:0] s01;
    logic signed [29:0] zmul;
    logic [31:0]        min_r2;
    logic [31:0]        max_r2;
    logic [31:0]        sc_mag;
    logic               sc_neg;
    logic               rot_on;
    logic [8:0][19:0]   coef;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        c;
    logic [63:0]        rem;
    logic [63:0]        root;
    logic signed [35:0] vx;
    logic signed [35:0] vy;
    logic signed [32:0] ang;
    logic [47:0]        deriv;
  } polar_t;

  typedef struct packed {
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        c;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [32:0] vz;
    logic [47:0]        deriv;
  } rot_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [47:0]      deriv;
  } vec_t;

  typedef struct packed {
    vec_t             v;
    logic             fold;
    logic [NUM_W-1:0] f;
  } fvec_t;

  // atan(2^-i) in Q.30, truncated
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd7;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ffs_polar.sv =====
// Front end: magnitudes, descending sort, then a pipelined square root of the
// squared radius running side by side with the CORDIC angle of (a, b). Uses ffs_pkg.
`default_nettype none

module ffs_polar
  import ffs_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [47:0]        in_deriv,
  output logic               out_vld,
  output polar_t             out_p
);

  localparam int NIT = 32;

  logic [31:0] ma, mb, mc, sa, sb, sc, t;

  always_comb begin
    ma = in_x[31] ? (32'd0 - $unsigned(in_x)) : $unsigned(in_x);
    mb = in_y[31] ? (32'd0 - $unsigned(in_y)) : $unsigned(in_y);
    mc = in_z[31] ? (32'd0 - $unsigned(in_z)) : $unsigned(in_z);
    sa = ma;
    sb = mb;
    sc = mc;
    t  = '0;
    if (sc > sb) begin
      t = sb; sb = sc; sc = t;
    end
    if (sb > sa) begin
      t = sa; sa = sb; sb = t;
    end
    if (sc > sb) begin
      t = sb; sb = sc; sc = t;
    end
  end

  logic        s0_vld_r, s1_vld_r;
  logic [31:0] a0_r, b0_r, c0_r, a1_r, b1_r, c1_r;
  logic [47:0] d0_r, d1_r;
  logic [63:0] aa_r, bb_r, cc_r;

  logic   vld_r [0:NIT];
  polar_t pl_r  [0:NIT];
  polar_t st0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
      vld_r[0] <= s1_vld_r;
    end
  end

  always_comb begin
    st0.a     = a1_r;
    st0.b     = b1_r;
    st0.c     = c1_r;
    st0.rem   = aa_r + bb_r + cc_r;
    st0.root  = '0;
    st0.vx    = $signed({4'b0, a1_r});
    st0.vy    = $signed({4'b0, b1_r});
    st0.ang   = '0;
    st0.deriv = d1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r     <= sa;
      b0_r     <= sb;
      c0_r     <= sc;
      d0_r     <= in_deriv;
      aa_r     <= {32'b0, a0_r} * {32'b0, a0_r};
      bb_r     <= {32'b0, b0_r} * {32'b0, b0_r};
      cc_r     <= {32'b0, c0_r} * {32'b0, c0_r};
      a1_r     <= a0_r;
      b1_r     <= b0_r;
      c1_r     <= c0_r;
      d1_r     <= d0_r;
      pl_r[0]  <= st0;
    end
  end

  for (genvar gi = 0; gi < NIT; gi++) begin : g_it
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gi);
    polar_t             nx;
    logic [64:0]        trial;
    logic signed [35:0] xs, ys;
    logic signed [32:0] at;

    always_comb begin
      nx    = pl_r[gi];
      trial = {1'b0, pl_r[gi].root} + {1'b0, BIT};
      xs    = pl_r[gi].vx >>> gi;
      ys    = pl_r[gi].vy >>> gi;
      at    = $signed({3'b000, atan_q30(5'(gi))});
      // one root digit per stage
      if ({1'b0, pl_r[gi].rem} >= trial) begin
        nx.rem  = pl_r[gi].rem - trial[63:0];
        nx.root = (pl_r[gi].root >> 1) + BIT;
      end else begin
        nx.root = pl_r[gi].root >> 1;
      end
      if (gi < CORDIC_STAGES) begin
        if (!pl_r[gi].vy[35]) begin
          nx.vx  = pl_r[gi].vx + ys;
          nx.vy  = pl_r[gi].vy - xs;
          nx.ang = pl_r[gi].ang + at;
        end else begin
          nx.vx  = pl_r[gi].vx - ys;
          nx.vy  = pl_r[gi].vy + xs;
          nx.ang = pl_r[gi].ang - at;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gi+1] <= 1'b0;
      end else if (adv) begin
        vld_r[gi+1] <= vld_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pl_r[gi+1] <= nx;
      end
    end
  end

  assign out_vld = vld_r[NIT];
  assign out_p   = pl_r[NIT];

endmodule

`default_nettype wire

// ===== rtl/ffs_rotor.sv =====
// Rotation CORDIC of (r*K, 0) by the half angle, then the spin twist and z stretch.
// Uses ffs_pkg; fed by ffs_polar.
`default_nettype none

module ffs_rotor
  import ffs_pkg::*;
#(
  parameter int FRAC_BITS     = 20,
  parameter int CORDIC_STAGES = 24
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  cfg_t   cfg,
  input  logic   in_vld,
  input  polar_t in_p,
  output logic   out_vld,
  output vec_t   out_v
);

  logic [61:0] kp;
  rot_t        r0;

  always_comb begin
    kp       = {30'b0, in_p.root[31:0]} * {32'b0, K_Q30};
    r0.a     = in_p.a;
    r0.b     = in_p.b;
    r0.c     = in_p.c;
    r0.cx    = $signed({4'b0, kp[61:30]});
    r0.cy    = '0;
    r0.vz    = in_p.ang >>> 1;
    r0.deriv = in_p.deriv;
  end

  logic vld_r [0:CORDIC_STAGES];
  rot_t rt_r  [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_r[0] <= r0;
    end
  end

  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_it
    rot_t               nx;
    logic signed [35:0] xs, ys;
    logic signed [32:0] at;

    always_comb begin
      nx = rt_r[gi];
      xs = rt_r[gi].cx >>> gi;
      ys = rt_r[gi].cy >>> gi;
      at = $signed({3'b000, atan_q30(5'(gi))});
      if (!rt_r[gi].vz[32]) begin
        nx.cx = rt_r[gi].cx - ys;
        nx.cy = rt_r[gi].cy + xs;
        nx.vz = rt_r[gi].vz - at;
      end else begin
        nx.cx = rt_r[gi].cx + ys;
        nx.cy = rt_r[gi].cy - xs;
        nx.vz = rt_r[gi].vz + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gi+1] <= 1'b0;
      end else if (adv) begin
        vld_r[gi+1] <= vld_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_r[gi+1] <= nx;
      end
    end
  end

  // spin products
  logic               s1_vld_r, s2_vld_r;
  logic signed [64:0] px_r, py_r;
  logic signed [63:0] pz_r;
  logic [31:0]        a1_r, b1_r;
  logic [47:0]        d1_r;
  vec_t               s2_r;

  logic signed [65:0] xe, ye, ze;
  vec_t               s2_nxt;

  always_comb begin
    xe = $signed({34'b0, a1_r}) + (px_r >>> FRAC_BITS);
    ye = $signed({34'b0, b1_r}) + (py_r >>> FRAC_BITS);
    ze = pz_r >>> FRAC_BITS;
    s2_nxt.p[0]  = sat32(xe);
    s2_nxt.p[1]  = sat32(ye);
    s2_nxt.p[2]  = sat32(ze);
    s2_nxt.deriv = d1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= vld_r[CORDIC_STAGES];
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= cfg.s01 * rt_r[CORDIC_STAGES].cx;
      py_r <= cfg.s01 * rt_r[CORDIC_STAGES].cy;
      pz_r <= $signed({1'b0, rt_r[CORDIC_STAGES].c}) * cfg.zmul;
      a1_r <= rt_r[CORDIC_STAGES].a;
      b1_r <= rt_r[CORDIC_STAGES].b;
      d1_r <= rt_r[CORDIC_STAGES].deriv;
      s2_r <= s2_nxt;
    end
  end

  assign out_vld = s2_vld_r;
  assign out_v   = s2_r;

endmodule

`default_nettype wire

// ===== rtl/ffs_fold_div.sv =====
// Squared radius, fold branch selection and a pipelined restoring divider for
// the fold factor, one quotient bit per stage. Uses ffs_pkg; fed by ffs_rotor.
`default_nettype none

module ffs_fold_div
  import ffs_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  cfg_t  cfg,
  input  logic  in_vld,
  input  vec_t  in_v,
  output logic  out_vld,
  output fvec_t out_f
);

  localparam int DEN_W = 64 - FRAC_BITS;

  typedef struct packed {
    vec_t             v;
    logic             fold;
    logic             dz;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] q;
  } div_t;

  logic             f0_vld_r;
  vec_t             f0_v_r;
  logic [2:0][63:0] sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
    end else if (adv) begin
      f0_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_v_r <= in_v;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= 64'($signed(in_v.p[k])) * 64'($signed(in_v.p[k]));
      end
    end
  end

  logic [63:0] rr, min_sh, max_sh;
  logic        inner, outer;
  div_t        d0;

  always_comb begin
    rr     = sq_r[0] + sq_r[1] + sq_r[2];
    min_sh = {32'b0, cfg.min_r2} << FRAC_BITS;
    max_sh = {32'b0, cfg.max_r2} << FRAC_BITS;
    inner  = rr < min_sh;
    outer  = rr < max_sh;
    d0.v    = f0_v_r;
    d0.fold = inner | outer;
    d0.den  = inner ? DEN_W'(cfg.min_r2) : rr[63:FRAC_BITS];
    d0.dz   = (d0.den == '0);
    d0.rem  = '0;
    d0.q    = '0;
  end

  logic             vld_r [0:NUM_W];
  div_t             dv_r  [0:NUM_W];
  logic [NUM_W-1:0] num;

  assign num = {cfg.max_r2, {FAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= f0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= d0;
    end
  end

  for (genvar gi = 0; gi < NUM_W; gi++) begin : g_div
    localparam int NB = NUM_W - 1 - gi;
    div_t           nx;
    logic [DEN_W:0] rem2;

    always_comb begin
      nx   = dv_r[gi];
      rem2 = {dv_r[gi].rem, num[NB]};
      if (rem2 >= {1'b0, dv_r[gi].den}) begin
        rem2   = rem2 - {1'b0, dv_r[gi].den};
        nx.q   = {dv_r[gi].q[NUM_W-2:0], 1'b1};
      end else begin
        nx.q   = {dv_r[gi].q[NUM_W-2:0], 1'b0};
      end
      nx.rem = rem2[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gi+1] <= 1'b0;
      end else if (adv) begin
        vld_r[gi+1] <= vld_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[gi+1] <= nx;
      end
    end
  end

  assign out_vld    = vld_r[NUM_W];
  assign out_f.v    = dv_r[NUM_W].v;
  assign out_f.fold = dv_r[NUM_W].fold;
  // a truncated radius of zero saturates the factor
  assign out_f.f    = dv_r[NUM_W].dz ? FACTOR_CAP : dv_r[NUM_W].q;

endmodule

`default_nettype wire

// ===== rtl/ffs_scale.sv =====
// Fold factor multiply, uniform scale, derivative update and the optional
// 3x3 rotation; holds the output register. Uses ffs_pkg; fed by ffs_fold_div.
`default_nettype none

module ffs_scale
  import ffs_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  cfg_t  cfg,
  input  logic  in_vld,
  input  fvec_t in_f,
  output logic  out_vld,
  output vec_t  out_v
);

  // saturate a magnitude product and apply the sign
  function automatic logic [31:0] sat_coord(input logic [63:0] mag, input logic neg);
    logic [32:0] cap, pv;
    cap = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    pv  = (mag > {31'b0, cap}) ? cap : mag[32:0];
    return neg ? 32'(33'd0 - pv) : pv[31:0];
  endfunction

  logic [5:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  // stage 0: partial products against the fold factor
  logic [2:0][31:0] m0_v_r;
  logic [2:0]       m0_neg_r;
  logic             m0_fold_r;
  logic [47:0]      m0_d_r;
  logic [2:0][59:0] m0_pl_r, m0_ph_r;
  logic [51:0]      m0_dll_r, m0_dlh_r, m0_dhl_r, m0_dhh_r;
  logic [2:0][31:0] mag0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag0[k] = in_f.v.p[k][31] ? (32'd0 - in_f.v.p[k]) : in_f.v.p[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_v_r    <= in_f.v.p;
      m0_fold_r <= in_f.fold;
      m0_d_r    <= in_f.v.deriv;
      for (int k = 0; k < 3; k++) begin
        m0_neg_r[k] <= in_f.v.p[k][31];
        m0_pl_r[k]  <= 60'(mag0[k]) * 60'(in_f.f[27:0]);
        m0_ph_r[k]  <= 60'(mag0[k]) * 60'(in_f.f[55:28]);
      end
      m0_dll_r <= 52'(in_f.v.deriv[23:0])  * 52'(in_f.f[27:0]);
      m0_dlh_r <= 52'(in_f.v.deriv[23:0])  * 52'(in_f.f[55:28]);
      m0_dhl_r <= 52'(in_f.v.deriv[47:24]) * 52'(in_f.f[27:0]);
      m0_dhh_r <= 52'(in_f.v.deriv[47:24]) * 52'(in_f.f[55:28]);
    end
  end

  // stage 1: combine, shift out the factor fraction, saturate
  logic [2:0][31:0] m1_v_r, m1_nxt;
  logic [47:0]      m1_d_r, d1_nxt;
  logic [87:0]      sum88;
  logic [103:0]     dsum;

  always_comb begin
    m1_nxt = m0_v_r;
    sum88  = '0;
    for (int k = 0; k < 3; k++) begin
      sum88 = {m0_ph_r[k], 28'b0} + {28'b0, m0_pl_r[k]};
      if (m0_fold_r) begin
        m1_nxt[k] = sat_coord(sum88[87:FAC_BITS], m0_neg_r[k]);
      end
    end
    dsum = (104'(m0_dhh_r) << 52) + (104'(m0_dhl_r) << 24) + (104'(m0_dlh_r) << 28)
         + 104'(m0_dll_r);
    if (!m0_fold_r) begin
      d1_nxt = m0_d_r;
    end else if (dsum[103:FAC_BITS] > 80'(DMAX)) begin
      d1_nxt = DMAX;
    end else begin
      d1_nxt = dsum[FAC_BITS+47:FAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_v_r <= m1_nxt;
      m1_d_r <= d1_nxt;
    end
  end

  // stage 2: uniform scale products
  logic [2:0][63:0] m2_p_r;
  logic [2:0]       m2_neg_r;
  logic [55:0]      m2_dl_r, m2_dh_r;
  logic [2:0][31:0] mag2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag2[k] = m1_v_r[k][31] ? (32'd0 - m1_v_r[k]) : m1_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        m2_p_r[k]   <= 64'(mag2[k]) * 64'(cfg.sc_mag);
        m2_neg_r[k] <= m1_v_r[k][31] ^ cfg.sc_neg;
      end
      m2_dl_r <= 56'(m1_d_r[23:0])  * 56'(cfg.sc_mag);
      m2_dh_r <= 56'(m1_d_r[47:24]) * 56'(cfg.sc_mag);
    end
  end

  // stage 3: scale shift and saturation
  logic [2:0][31:0] m3_v_r, m3_nxt;
  logic [47:0]      m3_d_r, d3_nxt;
  logic [80:0]      ds, dss;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m3_nxt[k] = sat_coord(m2_p_r[k] >> FRAC_BITS, m2_neg_r[k]);
    end
    ds  = (81'(m2_dh_r) << 24) + 81'(m2_dl_r);
    dss = ds >> FRAC_BITS;
    d3_nxt = (dss > 81'(DMAX)) ? DMAX : dss[47:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_v_r <= m3_nxt;
      m3_d_r <= d3_nxt;
    end
  end

  // stage 4: rotation products, derivative gains 1.0
  logic signed [51:0] rp_r [0:8];
  logic [2:0][31:0]   m4_v_r;
  logic [47:0]        m4_d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        rp_r[i] <= 52'($signed(cfg.coef[i])) * 52'($signed(m3_v_r[i % 3]));
      end
      m4_v_r <= m3_v_r;
      m4_d_r <= (m3_d_r > DMAX - ONE_Q24) ? DMAX : m3_d_r + ONE_Q24;
    end
  end

  // stage 5: row sums, output register
  logic signed [53:0] tsum;
  vec_t               o_nxt, o_r;

  always_comb begin
    o_nxt.deriv = m4_d_r;
    tsum        = '0;
    for (int k = 0; k < 3; k++) begin
      tsum = 54'(rp_r[3*k]) + 54'(rp_r[3*k+1]) + 54'(rp_r[3*k+2]);
      o_nxt.p[k] = cfg.rot_on ? sat32(66'(tsum >>> ROT_BITS)) : m4_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r <= o_nxt;
    end
  end

  assign out_vld = vld_r[5];
  assign out_v   = o_r;

endmodule

`default_nettype wire

// ===== rtl/fractal_fold_spin_iteration.sv =====
// Top level: register file, handshake control and the four pipeline sections.
// Depends on ffs_pkg, ffs_polar, ffs_rotor, ffs_fold_div and ffs_scale.
//
// One fractal iteration per point: magnitudes and sort, spin twist from a CORDIC
// angle and radius, spherical fold, uniform scale and optional rotation. A point
// is taken every cycle unless a result is stalled at the output; the pipeline depth is
// set by the 32-stage square root, the rotation CORDIC and the 56-stage fold
// divider. The whole pipeline holds while a finished result is stalled at the
// output. Configuration writes are taken at any time (cfg_ready is always high)
// and belong to idle periods.
`default_nettype none

module fractal_fold_spin_iteration
  import ffs_pkg::*;
#(
  parameter int FRAC_BITS     = 20,
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [47:0]        in_deriv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [47:0]        out_deriv,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [59:0]        cfg_data
);

  logic [31:0] spin_gain_r, min_r2_r, max_r2_r, scale_r;
  logic        rot_on_r;
  logic [59:0] row_a_r, row_b_r, row_c_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_gain_r <= 32'd838861;
      min_r2_r    <= 32'd262144;
      max_r2_r    <= 32'd1048576;
      scale_r     <= 32'd2097152;
      rot_on_r    <= 1'b0;
      row_a_r     <= 60'd262144;
      row_b_r     <= 60'd274877906944;
      row_c_r     <= 60'd288230376151711744;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPIN_GAIN:     spin_gain_r <= cfg_data[31:0];
        CFG_MIN_RADIUS_SQ: min_r2_r    <= cfg_data[31:0];
        CFG_MAX_RADIUS_SQ: max_r2_r    <= cfg_data[31:0];
        CFG_UNIFORM_SCALE: scale_r     <= cfg_data[31:0];
        CFG_ROTATE_ON:     rot_on_r    <= cfg_data[0];
        CFG_ROT_ROW_A:     row_a_r     <= cfg_data;
        CFG_ROT_ROW_B:     row_b_r     <= cfg_data;
        CFG_ROT_ROW_C:     row_c_r     <= cfg_data;
      endcase
    end
  end

  // derived settings, registered once
  logic signed [59:0] p01, p005;
  cfg_t               cfg_nxt, cfg_r;

  always_comb begin
    p01  = $signed(spin_gain_r) * $signed({1'b0, C01_Q30});
    p005 = $signed(spin_gain_r) * $signed({1'b0, C005_Q30});
    cfg_nxt.s01    = p01[58:30];
    cfg_nxt.zmul   = $signed(30'd1 << FRAC_BITS) + 30'($signed(p005[57:30]));
    cfg_nxt.min_r2 = min_r2_r;
    cfg_nxt.max_r2 = max_r2_r;
    cfg_nxt.sc_neg = scale_r[31];
    cfg_nxt.sc_mag = scale_r[31] ? (32'd0 - scale_r) : scale_r;
    cfg_nxt.rot_on = rot_on_r;
    for (int c = 0; c < 3; c++) begin
      cfg_nxt.coef[c]     = row_a_r[20*c +: 20];
      cfg_nxt.coef[3 + c] = row_b_r[20*c +: 20];
      cfg_nxt.coef[6 + c] = row_c_r[20*c +: 20];
    end
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  logic   adv;
  logic   pol_vld, rot_vld, fold_vld;
  polar_t pol_p;
  vec_t   rot_v, res_v;
  fvec_t  fold_f;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ffs_polar #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_polar (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .in_deriv (in_deriv),
    .out_vld  (pol_vld),
    .out_p    (pol_p)
  );

  ffs_rotor #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_rotor (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .in_vld  (pol_vld),
    .in_p    (pol_p),
    .out_vld (rot_vld),
    .out_v   (rot_v)
  );

  ffs_fold_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .in_vld  (rot_vld),
    .in_v    (rot_v),
    .out_vld (fold_vld),
    .out_f   (fold_f)
  );

  ffs_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .in_vld  (fold_vld),
    .in_f    (fold_f),
    .out_vld (out_valid),
    .out_v   (res_v)
  );

  assign out_x     = res_v.p[0];
  assign out_y     = res_v.p[1];
  assign out_z     = res_v.p[2];
  assign out_deriv = res_v.deriv;

endmodule

`default_nettype wire

// ===== verif/fractal_fold_spin_checker.sv =====
// Checker for fractal_fold_spin_iteration: tracks register writes, predicts each point's
// next iteration and compares it with the block's results. Depends on ffs_pkg.
`timescale 1ns / 1ps

module fractal_fold_spin_checker
  import ffs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [47:0]        in_deriv,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic [47:0]        out_deriv,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [59:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int FRAC   = 20;
  localparam int STAGES = 24;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [47:0]        deriv;
  } point_t;

  longint arctan [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0
  };

  logic signed [31:0] spin_gain, uniform_scale;
  logic [31:0]        min_r2, max_r2;
  logic               rot_on;
  logic [59:0]        rows [3];
  point_t             expected_points [$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // floor(m*f / 2^sh), clipped to cap
  function automatic logic [63:0] scaled_product(logic [63:0] m, logic [63:0] f, int sh,
                                                 logic [63:0] cap);
    logic [127:0] p;
    p = (128'(m) * 128'(f)) >> sh;
    return (p > 128'(cap)) ? cap : p[63:0];
  endfunction

  // magnitude multiply, truncated toward zero, then signed saturation
  function automatic longint scale_coord(longint v, logic [63:0] fmag, bit fneg, int sh);
    bit          neg;
    logic [63:0] mag, p;
    neg = (v < 0) != fneg;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    p = scaled_product(mag, fmag, sh, neg ? 64'd2147483648 : 64'd2147483647);
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic point_t iterate_point(logic signed [31:0] px, logic signed [31:0] py,
                                           logic signed [31:0] pz, logic [47:0] d_in);
    logic [63:0] a, b, c, tmp, r, rr, deriv, f, smag;
    longint vx, vy, ang, vz, cx, cy, xs, ys, s01, s005, sc, t;
    longint v [3];
    longint o [3];
    logic signed [19:0] cf;
    bit fold;
    point_t res;
    a = (px < 0) ? 64'(-longint'(px)) : 64'(px);
    b = (py < 0) ? 64'(-longint'(py)) : 64'(py);
    c = (pz < 0) ? 64'(-longint'(pz)) : 64'(pz);
    if (c > b) begin tmp = b; b = c; c = tmp; end
    if (b > a) begin tmp = a; a = b; b = tmp; end
    if (c > b) begin tmp = b; b = c; c = tmp; end
    r = int_sqrt(a * a + b * b + c * c);

    vx = longint'(a);
    vy = longint'(b);
    ang = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx += ys; vy -= xs; ang += arctan[i];
      end else begin
        vx -= ys; vy += xs; ang -= arctan[i];
      end
    end
    vz = ang >>> 1;
    cx = longint'((r * 64'd652032874) >> 30);
    cy = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (vz >= 0) begin
        cx -= ys; cy += xs; vz -= arctan[i];
      end else begin
        cx += ys; cy -= xs; vz += arctan[i];
      end
    end

    s01  = (longint'(spin_gain) * 64'sd107374182) >>> 30;
    s005 = (longint'(spin_gain) * 64'sd53687091) >>> 30;
    v[0] = clip32(longint'(a) + ((s01 * cx) >>> FRAC));
    v[1] = clip32(longint'(b) + ((s01 * cy) >>> FRAC));
    v[2] = clip32((longint'(c) * ((64'sd1 <<< FRAC) + s005)) >>> FRAC);

    rr = 64'(v[0] * v[0]) + 64'(v[1] * v[1]) + 64'(v[2] * v[2]);
    deriv = 64'(d_in);
    fold = 1'b0;
    f = 0;
    if (rr < (64'(min_r2) << FRAC)) begin
      f = (64'(max_r2) << 24) / 64'(min_r2);
      fold = 1'b1;
    end else if (rr < (64'(max_r2) << FRAC)) begin
      f = ((rr >> FRAC) == 0) ? (64'hFFFF_FFFF << 24) : (64'(max_r2) << 24) / (rr >> FRAC);
      fold = 1'b1;
    end
    if (fold) begin
      for (int k = 0; k < 3; k++) v[k] = scale_coord(v[k], f, 1'b0, 24);
      deriv = scaled_product(deriv, f, 24, 64'(DMAX));
    end

    sc = longint'(uniform_scale);
    smag = (sc < 0) ? 64'(-sc) : 64'(sc);
    for (int k = 0; k < 3; k++) v[k] = scale_coord(v[k], smag, sc < 0, FRAC);
    deriv = scaled_product(deriv, smag, FRAC, 64'(DMAX));
    deriv = (deriv > 64'(DMAX) - (64'd1 << 24)) ? 64'(DMAX) : deriv + (64'd1 << 24);

    if (rot_on) begin
      for (int k = 0; k < 3; k++) begin
        t = 0;
        for (int j = 0; j < 3; j++) begin
          cf = rows[k][20*j +: 20];
          t += longint'(cf) * v[j];
        end
        o[k] = clip32(t >>> 18);
      end
      for (int k = 0; k < 3; k++) v[k] = o[k];
    end

    res.x = v[0][31:0];
    res.y = v[1][31:0];
    res.z = v[2][31:0];
    res.deriv = deriv[47:0];
    return res;
  endfunction

  assign pending = expected_points.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      spin_gain     <= 32'sd838861;
      min_r2        <= 32'd262144;
      max_r2        <= 32'd1048576;
      uniform_scale <= 32'sd2097152;
      rot_on        <= 1'b0;
      rows[0]       <= 60'd262144;
      rows[1]       <= 60'd274877906944;
      rows[2]       <= 60'd288230376151711744;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPIN_GAIN:     spin_gain     <= cfg_data[31:0];
          CFG_MIN_RADIUS_SQ: min_r2        <= cfg_data[31:0];
          CFG_MAX_RADIUS_SQ: max_r2        <= cfg_data[31:0];
          CFG_UNIFORM_SCALE: uniform_scale <= cfg_data[31:0];
          CFG_ROTATE_ON:     rot_on        <= cfg_data[0];
          CFG_ROT_ROW_A:     rows[0]       <= cfg_data;
          CFG_ROT_ROW_B:     rows[1]       <= cfg_data;
          CFG_ROT_ROW_C:     rows[2]       <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_points.push_back(iterate_point(in_x, in_y, in_z, in_deriv));
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("result with no point outstanding");
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          if (out_x !== want.x) begin
            $error("out_x expected %0d got %0d", want.x, out_x);
            fail_count++;
          end
          if (out_y !== want.y) begin
            $error("out_y expected %0d got %0d", want.y, out_y);
            fail_count++;
          end
          if (out_z !== want.z) begin
            $error("out_z expected %0d got %0d", want.z, out_z);
            fail_count++;
          end
          if (out_deriv !== want.deriv) begin
            $error("out_deriv expected %0h got %0h", want.deriv, out_deriv);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_fractal_fold_spin_iteration.sv =====
// Testbench top for fractal_fold_spin_iteration: clock, reset, register setup and point
// stimulus with random idling. Depends on ffs_pkg and fractal_fold_spin_checker.
`timescale 1ns / 1ps

module tb_fractal_fold_spin_iteration;
  import ffs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 200;

  logic               clk, rst_n;
  logic               in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] in_x, in_y, in_z, out_x, out_y, out_z;
  logic [47:0]        in_deriv, out_deriv;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [59:0]        cfg_data;
  int                 fail_count, pending;
  int                 send_idle_pct, recv_stall_pct;
  bit                 hold_request;
  int                 cycles;

  fractal_fold_spin_iteration dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_x, .in_y, .in_z, .in_deriv,
    .out_valid, .out_stall, .out_x, .out_y, .out_z, .out_deriv,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  fractal_fold_spin_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_x, .in_y, .in_z, .in_deriv,
    .out_valid, .out_stall, .out_x, .out_y, .out_z, .out_deriv,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fractal_fold_spin_iteration");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold-off on request so the pipe backs up
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [59:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic [47:0] d);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_x = x;
    in_y = y;
    in_z = z;
    in_deriv = d;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
  endtask

  function automatic logic [31:0] rand_coord();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(31, 0);
  endfunction

  function automatic logic [47:0] rand_deriv();
    logic [47:0] d;
    d = 48'({$urandom, $urandom});
    return d >> $urandom_range(47, 0);
  endfunction

  function automatic logic [59:0] rand_row();
    return 60'({$urandom, $urandom} >> $urandom_range(4, 0));
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic random_points(input int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), rand_deriv());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x = '0; in_y = '0; in_z = '0; in_deriv = '0;
    cfg_valid = 1'b0; cfg_index = CFG_SPIN_GAIN; cfg_data = '0;
    send_idle_pct = 36;
    recv_stall_pct = 85;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, each fold branch, sort orders
    send_point(32'h0, 32'h0, 32'h0, 48'h0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h1, 32'h0, 48'h1);
    send_point(32'h0004_0000, 32'hFFFC_0000, 32'h0002_0000, 48'h0000_0100_0000);
    send_point(32'h000C_0000, 32'h0008_0000, 32'hFFF8_0000, 48'h0000_0100_0000);
    send_point(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 48'h0000_0100_0000);
    send_point(32'h0000_1000, 32'hFF00_0000, 32'h0001_0000, 48'h8000_0000_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 48'h0000_00FF_FFFF);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 48'h5555_5555_5555);
    wait_idle();

    // negative scale, extreme gain, rotation with edge coefficients
    write_reg(CFG_SPIN_GAIN, 60'h0000_0000_8000_0000);
    write_reg(CFG_UNIFORM_SCALE, 60'h0000_0000_FFE0_0000);
    write_reg(CFG_ROTATE_ON, 60'h1);
    write_reg(CFG_ROT_ROW_A, 60'h7FFFF_80000_7FFFF);
    write_reg(CFG_ROT_ROW_B, 60'h80000_80000_80000);
    write_reg(CFG_ROT_ROW_C, 60'hFFFFF_FFFFF_FFFFF);
    send_point(32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000, 48'h0000_0100_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);
    send_point(32'h0000_8000, 32'h0000_0000, 32'h0000_4000, 48'h0);
    random_points(20);
    wait_idle();

    // tightest fold radii, maximum gain and scale
    write_reg(CFG_SPIN_GAIN, 60'h0000_0000_7FFF_FFFF);
    write_reg(CFG_MIN_RADIUS_SQ, 60'h1);
    write_reg(CFG_MAX_RADIUS_SQ, 60'h0);
    write_reg(CFG_UNIFORM_SCALE, 60'h0000_0000_7FFF_FFFF);
    write_reg(CFG_ROTATE_ON, 60'h0);
    random_points(60);
    wait_idle();

    // widest fold radii, minimum scale
    write_reg(CFG_MIN_RADIUS_SQ, 60'h0000_0000_FFFF_FFFF);
    write_reg(CFG_MAX_RADIUS_SQ, 60'h0000_0000_FFFF_FFFF);
    write_reg(CFG_UNIFORM_SCALE, 60'h0000_0000_8000_0000);
    random_points(60);
    wait_idle();

    send_idle_pct = 85;
    recv_stall_pct = 36;
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_SPIN_GAIN, 60'($signed($urandom) >>> $urandom_range(12, 0)));
      write_reg(CFG_MIN_RADIUS_SQ, 60'($urandom_range(32'h0040_0000, 1)));
      write_reg(CFG_MAX_RADIUS_SQ, 60'($urandom_range(32'h0400_0000, 0)));
      write_reg(CFG_UNIFORM_SCALE, 60'($signed($urandom) >>> $urandom_range(12, 4)));
      write_reg(CFG_ROTATE_ON, 60'($urandom_range(1)));
      write_reg(CFG_ROT_ROW_A, rand_row());
      write_reg(CFG_ROT_ROW_B, rand_row());
      write_reg(CFG_ROT_ROW_C, rand_row());
      random_points(70);
      wait_idle();
    end

    // no idling; a long receiver hold fills the pipe and stalls the input
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_SPIN_GAIN, 60'd838861);
    write_reg(CFG_MIN_RADIUS_SQ, 60'd262144);
    write_reg(CFG_MAX_RADIUS_SQ, 60'd1048576);
    write_reg(CFG_UNIFORM_SCALE, 60'd2097152);
    write_reg(CFG_ROTATE_ON, 60'h1);
    hold_request = 1'b1;
    random_points(190);
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS fractal_fold_spin_iteration");
    end else begin
      $display("FAIL fractal_fold_spin_iteration");
    end
    $finish;
  end

endmodule
